// File: rtl/tmce_pkg.sv
// shared types and constants for the text mode console engine
// operation codes, character codes, sequencer states and the result record
// no dependencies
package tmce_pkg;

  localparam int POS_W = 11;
  localparam int IDX_W = 11;
  localparam int CELL_W = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int IN_TDATA_W = 32;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] ATTR_RESET = 8'h05;
  localparam int TAB_STEP = 4;
  localparam int TAB_BITS = $clog2(TAB_STEP);

  typedef enum logic [1:0] {
    OP_PUT      = 2'd0,
    OP_SET_ATTR = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_READ,
    ST_SWEEP,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [7:0]       read_attr;
    logic [7:0]       read_char;
    logic [7:0]       echo_char;
    logic [POS_W-1:0] cursor_position;
  } result_t;

endpackage

// File: rtl/tmce_ram.sv
// generic single write port, single read port ram with registered read data
// read during write to the same address returns the old contents
// no dependencies
module tmce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/text_mode_console_engine.sv
// text mode console engine top level: cursor, attribute and sweep sequencer
// around one cell ram holding character (7:0) and attribute (15:8) per cell
// depends on tmce_pkg and tmce_ram
//
// channel   dir   handshake              payload
// in_       in    in_tvalid / in_tready   tuser: op; tdata: char_code, attr_value,
//                                         cell_index
// out_      out   out_tvalid / out_tready tdata: cursor_position, echo_char,
//                                         read_char, read_attr
//
// put of a printable character, set attribute and read cell: one
// ram access at accept, then the registered read data is checked (space recolor)
// or returned. newline and tab without scroll finish at accept.
// clear and scroll sweep the whole cell ram through its single write port;
// no item is taken during the sweep.
// reset (rst_n low, synchronous) homes the cursor and sets the attribute to 0x05;
// cell contents are undefined until the first clear.
// the result sits in an output register; a new item is taken while it waits,
// and the sequencer only holds when a second result is ready before the first
// transfer completes.
module text_mode_console_engine #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [1:0]                    in_tuser,   // op
  input  logic [tmce_pkg::IN_TDATA_W-1:0] in_tdata, // char_code, attr_value,
                                                    // cell_index, zero pad
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tmce_pkg::OUT_TDATA_W-1:0] out_tdata // cursor_position, echo_char,
                                                     // read_char, read_attr, pad
);

  import tmce_pkg::*;

  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int AW = $clog2(CELL_COUNT);
  localparam int CW = $clog2(CELL_COUNT + 1);
  localparam int CLW = $clog2(SCREEN_COLUMNS);
  localparam int RW = (SCREEN_ROWS > 2) ? $clog2(SCREEN_ROWS) : 1;
  localparam int IW = (AW > IDX_W) ? AW : IDX_W;
  localparam int LAST_BASE = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
  localparam int RES_W = $bits(result_t);

  // input fields
  op_t              in_op;
  logic [7:0]       in_char;
  logic [7:0]       in_attr;
  logic [IW-1:0]    idx_w;

  assign in_op   = op_t'(in_tuser);
  assign in_char = in_tdata[7:0];
  assign in_attr = in_tdata[15:8];
  assign idx_w   = IW'(in_tdata[26:16]);

  // state registers
  state_t           state_r, state_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [CLW-1:0]   col_r, col_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;     // linear cursor cell, row*columns+column
  logic [7:0]       attr_r, attr_nxt;
  logic [7:0]       echo_r, echo_nxt;
  logic             rd_ok_r, rd_ok_nxt;
  logic             copy_r, copy_nxt;     // sweep copies rows up (scroll) or blanks
  logic [CW-1:0]    scan_r, scan_nxt;     // sweep destination at read issue
  logic             pend_v_r, pend_v_nxt; // sweep write stage
  logic [AW-1:0]    pend_dst_r, pend_dst_nxt;
  logic             pend_copy_r, pend_copy_nxt;
  result_t          res_r, res_nxt;       // result waiting for the output register
  logic             out_valid_r, out_valid_nxt;
  result_t          out_res_r, out_res_nxt;

  // ram port
  logic              ram_we;
  logic [AW-1:0]     ram_wa;
  logic [CELL_W-1:0] ram_wd;
  logic [AW-1:0]     ram_ra;
  logic [CELL_W-1:0] ram_rdata;

  tmce_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (ram_ra),
    .rdata (ram_rdata)
  );

  // cursor arithmetic
  logic             last_row;
  logic             last_col;
  logic [CLW:0]     tab_sum;
  logic [CLW-1:0]   tab_col;
  logic [AW-1:0]    nl_addr;
  logic [AW-1:0]    tab_addr;
  logic [AW-1:0]    next_addr;
  logic [CW:0]      sweep_src;
  logic             out_free;
  logic             finish;
  logic [7:0]       fin_rch;
  logic [7:0]       fin_rattr;
  result_t          fin_res;

  assign last_row = (row_r == RW'(SCREEN_ROWS - 1));
  assign last_col = (col_r == CLW'(SCREEN_COLUMNS - 1));

  // next multiple of the tab step, wrapped once at the line end
  always_comb begin
    tab_sum = (CLW+1)'(col_r) + (CLW+1)'(TAB_STEP) - (CLW+1)'(col_r[TAB_BITS-1:0]);
    if (tab_sum >= (CLW+1)'(SCREEN_COLUMNS)) begin
      tab_col = CLW'(tab_sum - (CLW+1)'(SCREEN_COLUMNS));
    end else begin
      tab_col = CLW'(tab_sum);
    end
  end

  assign nl_addr   = AW'((AW+1)'(addr_r) - (AW+1)'(col_r) + (AW+1)'(SCREEN_COLUMNS));
  assign tab_addr  = AW'((AW+1)'(addr_r) - (AW+1)'(col_r) + (AW+1)'(tab_col));
  assign next_addr = AW'((AW+1)'(addr_r) + (AW+1)'(1));
  assign sweep_src = (CW+1)'(scan_r) + (CW+1)'(SCREEN_COLUMNS);

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    addr_nxt      = addr_r;
    attr_nxt      = attr_r;
    echo_nxt      = echo_r;
    rd_ok_nxt     = rd_ok_r;
    copy_nxt      = copy_r;
    scan_nxt      = scan_r;
    pend_v_nxt    = 1'b0;
    pend_dst_nxt  = pend_dst_r;
    pend_copy_nxt = pend_copy_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    ram_we        = 1'b0;
    ram_wa        = addr_r;
    ram_wd        = '0;
    ram_ra        = addr_r;
    finish        = 1'b0;
    fin_rch       = '0;
    fin_rattr     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          echo_nxt = (in_op == OP_PUT) ? in_char : 8'd0;
          unique case (in_op)
            OP_PUT: begin
              priority if (in_char == CH_NEWLINE) begin
                col_nxt = '0;
                if (last_row) begin
                  // scroll: cursor lands on column 0 of the bottom row
                  row_nxt   = RW'(SCREEN_ROWS - 1);
                  addr_nxt  = AW'(LAST_BASE);
                  copy_nxt  = 1'b1;
                  scan_nxt  = '0;
                  state_nxt = ST_SWEEP;
                end else begin
                  row_nxt  = row_r + RW'(1);
                  addr_nxt = nl_addr;
                  finish   = 1'b1;
                end
              end else if (in_char == CH_TAB) begin
                col_nxt  = tab_col;
                addr_nxt = tab_addr;
                finish   = 1'b1;
              end else begin
                // write the character, then look at the cell under the new cursor
                ram_we = 1'b1;
                ram_wa = addr_r;
                ram_wd = {attr_r, in_char};
                if (last_col && last_row) begin
                  // the bottom row is blanked, so no space recolor is needed
                  row_nxt   = RW'(SCREEN_ROWS - 1);
                  col_nxt   = '0;
                  addr_nxt  = AW'(LAST_BASE);
                  copy_nxt  = 1'b1;
                  scan_nxt  = '0;
                  state_nxt = ST_SWEEP;
                end else begin
                  if (last_col) begin
                    col_nxt = '0;
                    row_nxt = row_r + RW'(1);
                  end else begin
                    col_nxt = col_r + CLW'(1);
                  end
                  addr_nxt  = next_addr;
                  ram_ra    = next_addr;
                  state_nxt = ST_RMW;
                end
              end
            end
            OP_SET_ATTR: begin
              attr_nxt  = in_attr;
              ram_ra    = addr_r;
              state_nxt = ST_RMW;
            end
            OP_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              addr_nxt  = '0;
              copy_nxt  = 1'b0;
              scan_nxt  = '0;
              state_nxt = ST_SWEEP;
            end
            OP_READ: begin
              ram_ra    = idx_w[AW-1:0];
              rd_ok_nxt = (idx_w < IW'(CELL_COUNT));
              state_nxt = ST_READ;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_RMW: begin
        // a space under the cursor takes the current attribute
        if (ram_rdata[7:0] == CH_SPACE) begin
          ram_we = 1'b1;
          ram_wa = addr_r;
          ram_wd = {attr_r, CH_SPACE};
        end
        finish = 1'b1;
      end

      ST_READ: begin
        if (rd_ok_r) begin
          fin_rch   = ram_rdata[7:0];
          fin_rattr = ram_rdata[15:8];
        end
        finish = 1'b1;
      end

      ST_SWEEP: begin
        // read stage: fetch the source one row below the destination (the bottom row reads itself)
        if (scan_r != CW'(CELL_COUNT)) begin
          pend_v_nxt    = 1'b1;
          pend_dst_nxt  = scan_r[AW-1:0];
          pend_copy_nxt = copy_r && (scan_r < CW'(LAST_BASE));
          scan_nxt      = scan_r + CW'(1);
          ram_ra        = (scan_r < CW'(LAST_BASE)) ? AW'(sweep_src) : scan_r[AW-1:0];
        end else begin
          finish = 1'b1;
        end
        // write stage: copied character or a space, always with the current attribute
        if (pend_v_r) begin
          ram_we = 1'b1;
          ram_wa = pend_dst_r;
          ram_wd = {attr_r, pend_copy_r ? ram_rdata[7:0] : CH_SPACE};
        end
      end

      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    fin_res.cursor_position = POS_W'(addr_nxt);
    fin_res.echo_char       = echo_nxt;
    fin_res.read_char       = fin_rch;
    fin_res.read_attr       = fin_rattr;

    if (finish) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = fin_res;
        state_nxt     = ST_IDLE;
      end else begin
        res_nxt   = fin_res;
        state_nxt = ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      addr_r      <= '0;
      attr_r      <= ATTR_RESET;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      addr_r      <= addr_nxt;
      attr_r      <= attr_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and sweep bookkeeping, set before use
  always_ff @(posedge clk) begin
    echo_r      <= echo_nxt;
    rd_ok_r     <= rd_ok_nxt;
    copy_r      <= copy_nxt;
    scan_r      <= scan_nxt;
    pend_dst_r  <= pend_dst_nxt;
    pend_copy_r <= pend_copy_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - RES_W)'(0), out_res_r};

endmodule

// File: tb/text_mode_console_engine_tb.sv
// self-checking testbench for text_mode_console_engine: directed and random
// console traffic checked against an in-bench screen, cursor and attribute model
// depends on tmce_pkg and the engine rtl
`timescale 1ns / 1ps

module text_mode_console_engine_tb;
  import tmce_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLS * ROWS;
  // clear and scroll walk the whole cell ram
  localparam int SWEEP_CYCLES = CELLS + 1;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_PRINTED = 40;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic [1:0]             in_tuser = '0;   // op
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // char_code, attr_value, cell_index, pad
  logic                   out_tready = 1'b0;
  wire                    in_tready;
  wire                    out_tvalid;
  wire [OUT_TDATA_W-1:0]  out_tdata;       // cursor_position, echo_char, read_char,
                                           // read_attr, pad

  text_mode_console_engine #(
    .SCREEN_COLUMNS(COLS),
    .SCREEN_ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // console model: screen cells, cursor and current attribute
  // ---------------------------------------------------------------------------
  logic [CELL_W-1:0] screen_mem [CELLS];   // unknown until the first clear
  logic [4:0]        cur_row = '0;
  logic [6:0]        cur_col = '0;
  logic [7:0]        cur_attr = ATTR_RESET;

  result_t pending_results[$];             // expected results, oldest first

  int error_count = 0;
  int checked_count = 0;
  int scroll_count = 0;
  int op_count [4] = '{0, 0, 0, 0};
  int burst_left = 0;

  function automatic int cell_addr(int r, int c);
    return (r * COLS + c) % CELLS;
  endfunction

  // a space under the cursor takes the current attribute
  function void recolor_under_cursor();
    int a;
    a = cell_addr(cur_row, cur_col);
    if (screen_mem[a][7:0] == CH_SPACE) screen_mem[a] = {cur_attr, CH_SPACE};
  endfunction

  function automatic result_t apply_console_op(op_t op, logic [7:0] ch, logic [7:0] attr,
                                               logic [IDX_W-1:0] idx);
    result_t res;
    int r;
    int c;
    res = '0;
    case (op)
      OP_PUT: begin
        res.echo_char = ch;
        if (ch == CH_NEWLINE) begin
          cur_row = cur_row + 5'd1;
          cur_col = '0;
        end else if (ch == CH_TAB) begin
          cur_col = 7'((int'(cur_col) + TAB_STEP - int'(cur_col) % TAB_STEP) % COLS);
        end else begin
          screen_mem[cell_addr(cur_row, cur_col)] = {cur_attr, ch};
          cur_col = cur_col + 7'd1;
          if (cur_col >= COLS) begin
            cur_col = '0;
            cur_row = cur_row + 5'd1;
          end
        end
        // past the bottom row: shift everything up, recolored, blank the last row
        if (cur_row >= ROWS) begin
          for (r = 1; r < ROWS; r++)
            for (c = 0; c < COLS; c++)
              screen_mem[cell_addr(r - 1, c)] = {cur_attr, screen_mem[cell_addr(r, c)][7:0]};
          for (c = 0; c < COLS; c++)
            screen_mem[cell_addr(ROWS - 1, c)] = {cur_attr, CH_SPACE};
          cur_row = 5'(ROWS - 1);
          cur_col = '0;
          scroll_count++;
        end
        if (ch != CH_NEWLINE && ch != CH_TAB) recolor_under_cursor();
      end
      OP_SET_ATTR: begin
        cur_attr = attr;
        recolor_under_cursor();
      end
      OP_CLEAR: begin
        for (r = 0; r < CELLS; r++) screen_mem[r] = {cur_attr, CH_SPACE};
        cur_row = '0;
        cur_col = '0;
      end
      default: begin
        if (idx < CELLS) begin
          res.read_char = screen_mem[idx][7:0];
          res.read_attr = screen_mem[idx][15:8];
        end
      end
    endcase
    res.cursor_position = POS_W'(int'(cur_row) * COLS + int'(cur_col));
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: bursts of random length, random gaps between them, and now and
  // then a long burst with no gap at all
  // ---------------------------------------------------------------------------
  task automatic send_item(op_t op, logic [7:0] ch, logic [7:0] attr, logic [IDX_W-1:0] idx);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, idx, attr, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // transfer done at this edge: predict its result
    pending_results.push_back(apply_console_op(op, ch, attr, idx));
    op_count[op]++;
    burst_left--;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall pattern is picked at random among always ready,
  // coin flip and a fixed 4-of-7 duty; a hold-off request forces a long stall
  // ---------------------------------------------------------------------------
  logic hold_request = 1'b0;   // toggled by the pressure test
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   rx_mode = 0;
  int   rx_cycle = 0;

  always @(posedge clk) begin : receiver
    logic ready_next;
    if (hold_request != hold_seen) begin
      hold_seen = hold_request;
      hold_left = HOLD_OFF_CYCLES;
    end
    rx_cycle++;
    if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else begin
      case (rx_mode)
        0:       ready_next = 1'b1;
        1:       ready_next = 1'($urandom_range(0, 1));
        default: ready_next = (rx_cycle % 7) < 4;
      endcase
    end
    out_tready <= ready_next;
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                checked_count, name, got, want));
  endtask

  always @(posedge clk) begin : result_checker
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[$bits(result_t)-1:0]);
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = pending_results.pop_front();
        check_field("cursor_position", got.cursor_position, want.cursor_position);
        check_field("echo_char", got.echo_char, want.echo_char);
        check_field("read_char", got.read_char, want.read_char);
        check_field("read_attr", got.read_attr, want.read_attr);
        checked_count++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // the first operation must be a clear: the cell ram is unknown before it
  task automatic test_clear_and_read();
    send_item(OP_CLEAR, 8'h00, 8'h00, '0);
    send_item(OP_READ, 8'h00, 8'h00, 11'd0);
    send_item(OP_READ, 8'hFF, 8'hFF, 11'(CELLS - 1));
  endtask

  // character extremes; the space put leaves the cursor on a cleared space
  task automatic test_put_extremes();
    send_item(OP_PUT, 8'h00, 8'h00, '0);
    send_item(OP_PUT, 8'hFF, 8'hFF, '1);
    send_item(OP_PUT, CH_SPACE, 8'h00, '0);
    send_item(OP_READ, 8'h00, 8'h00, 11'd1);
  endtask

  // new attribute recolors the space under the cursor
  task automatic test_attribute_recolor();
    send_item(OP_SET_ATTR, 8'h00, 8'hFF, '0);
    send_item(OP_READ, 8'h00, 8'h00, 11'(int'(cur_row) * COLS + int'(cur_col)));
    send_item(OP_SET_ATTR, 8'h00, 8'h00, '0);
    send_item(OP_SET_ATTR, 8'h00, 8'hA5, '0);
  endtask

  task automatic test_tab_and_newline();
    send_item(OP_PUT, CH_TAB, 8'h00, '0);
    send_item(OP_PUT, CH_TAB, 8'h00, '0);
    send_item(OP_PUT, CH_NEWLINE, 8'h00, '0);
    send_item(OP_PUT, CH_TAB, 8'h00, '0);
  endtask

  // indexes at and past the cell count read zero; 0x400 is a read inside the range
  task automatic test_read_range();
    send_item(OP_READ, 8'h00, 8'h00, 11'(CELLS));
    send_item(OP_READ, 8'h00, 8'h00, 11'h7FF);
    send_item(OP_READ, 8'h00, 8'h00, 11'h400);
  endtask

  // walk down to the bottom row with short lines, then newline there scrolls
  task automatic test_scroll();
    while (cur_row != ROWS - 1) begin
      send_item(OP_PUT, 8'($urandom_range(33, 126)), 8'h00, '0);
      send_item(OP_PUT, CH_NEWLINE, 8'h00, '0);
    end
    send_item(OP_PUT, CH_NEWLINE, 8'h00, '0);
    send_item(OP_READ, 8'h00, 8'h00, 11'((ROWS - 2) * COLS));
    send_item(OP_READ, 8'h00, 8'h00, 11'((ROWS - 1) * COLS));
  endtask

  // lines of random content ending in a newline; most are short, some run
  // past the line end so the cursor wraps, and a rare clear homes the cursor
  task automatic test_random_lines(int n_items);
    int sent;
    int line_len;
    int pick;
    int i;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 29) == 0) begin
        send_item(OP_CLEAR, 8'($urandom), 8'($urandom), 11'($urandom));
        sent++;
      end
      line_len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 110) : $urandom_range(0, 12);
      for (i = 0; i < line_len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60)
          send_item(OP_PUT, 8'($urandom), 8'($urandom), 11'($urandom));
        else if (pick < 72)
          send_item(OP_PUT, CH_SPACE, 8'($urandom), 11'($urandom));
        else if (pick < 78)
          send_item(OP_PUT, CH_TAB, 8'($urandom), 11'($urandom));
        else if (pick < 84)
          send_item(OP_SET_ATTR, 8'($urandom), 8'($urandom), 11'($urandom));
        else if (pick < 93)
          send_item(OP_READ, 8'($urandom), 8'($urandom), 11'($urandom));
        else
          send_item(OP_READ, 8'($urandom), 8'($urandom),
                    11'(int'(cur_row) * COLS + int'(cur_col) + $urandom_range(0, 2) - 1));
      end
      send_item(OP_PUT, CH_NEWLINE, 8'($urandom), 11'($urandom));
      sent += line_len + 1;
    end
  endtask

  // receiver holds off for a long stretch while fast items keep coming,
  // so the engine fills up and drops in_tready
  task automatic test_backpressure();
    int i;
    hold_request <= ~hold_request;
    for (i = 0; i < 40; i++) begin
      case (i % 3)
        0:       send_item(OP_READ, 8'($urandom), 8'($urandom), 11'($urandom));
        1:       send_item(OP_SET_ATTR, 8'($urandom), 8'($urandom), 11'($urandom));
        default: send_item(OP_PUT, CH_TAB, 8'($urandom), 11'($urandom));
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence of tests and end of run
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_clear_and_read();
    test_put_extremes();
    test_attribute_recolor();
    test_tab_and_newline();
    test_read_range();
    test_scroll();
    test_random_lines(600);
    test_backpressure();
    test_random_lines(600);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // anything further out of the engine now is a stray result
    repeat (SWEEP_CYCLES + 16) @(posedge clk);

    $display("ran %0d puts, %0d attribute sets, %0d clears and %0d reads, with %0d scrolls",
             op_count[OP_PUT], op_count[OP_SET_ATTR], op_count[OP_CLEAR], op_count[OP_READ],
             scroll_count);
    $display("%0d results checked, %0d mismatches", checked_count, error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hard limit far beyond the slowest correct run
  initial begin
    #100_000_000;
    $display("timeout with %0d results still expected", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
